// ===== sv/hbp_pkg.sv =====
`default_nettype none
package hbp_pkg;

  localparam int BYTE_BITS = 8;

  // input field widths
  localparam int KIND_W   = 2;
  localparam int SYMBOL_W = 8;
  localparam int CODE_W   = 30;
  localparam int LEN_W    = 5;

  // tdata layout of the slave side
  localparam int S_DATA_W = 48;

  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ENCODE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

endpackage
`default_nettype wire

// ===== sv/hbp_ram.sv =====
`default_nettype none
module hbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/hbp_queue.sv =====
`default_nettype none
module hbp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  wr_ready,
  input  wire logic             rd_en,
  output logic                  rd_valid,
  output logic      [WIDTH-1:0] rd_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = (count != CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr_en && wr_ready;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ===== sv/hbp_front.sv =====
`default_nettype none
module hbp_front #(
  parameter int SYMBOL_COUNT = 256,
  parameter int MAX_CODE_LEN = 30
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [hbp_pkg::KIND_W-1:0]      kind,
  input  wire logic [hbp_pkg::SYMBOL_W-1:0]    symbol,
  input  wire logic [hbp_pkg::CODE_W-1:0]      code_bits,
  input  wire logic [hbp_pkg::LEN_W-1:0]       code_length,
  output logic                                 q_wr,
  output logic [MAX_CODE_LEN+$clog2(MAX_CODE_LEN+1):0] q_data,
  input  wire logic                            q_ready
);

  localparam int LW = $clog2(MAX_CODE_LEN + 1);
  localparam int AW = $clog2(SYMBOL_COUNT);
  localparam int EW = MAX_CODE_LEN + LW;

  logic                    accept;
  logic                    sym_ok;
  logic [LW-1:0]           len_sat;
  logic [MAX_CODE_LEN-1:0] code_masked;
  logic [EW-1:0]           rd_entry;
  logic                    stage_valid;
  logic                    stage_flush;
  logic                    push;

  assign sym_ok = ({1'b0, symbol} < (hbp_pkg::SYMBOL_W + 1)'(SYMBOL_COUNT));
  assign len_sat = (code_length > hbp_pkg::LEN_W'(MAX_CODE_LEN)) ?
                   LW'(MAX_CODE_LEN) : LW'(code_length);
  assign code_masked = code_bits[MAX_CODE_LEN-1:0] &
                       ~({MAX_CODE_LEN{1'b1}} << len_sat);

  // table read data holds while the stage waits on the queue
  assign push     = stage_valid && q_ready;
  assign in_ready = !stage_valid || push;
  assign accept   = in_valid && in_ready;

  hbp_ram #(
    .WIDTH(EW),
    .DEPTH(SYMBOL_COUNT)
  ) u_table (
    .clk  (clk),
    .we   (accept && (kind == hbp_pkg::KIND_LOAD) && sym_ok),
    .waddr(symbol[AW-1:0]),
    .wdata({len_sat, code_masked}),
    .re   (accept),
    .raddr(symbol[AW-1:0]),
    .rdata(rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      stage_flush <= 1'b0;
    end else if (accept) begin
      stage_valid <= (kind == hbp_pkg::KIND_FLUSH) ||
                     ((kind == hbp_pkg::KIND_ENCODE) && sym_ok);
      stage_flush <= (kind == hbp_pkg::KIND_FLUSH);
    end else if (push) begin
      stage_valid <= 1'b0;
    end
  end

  // zero-length codes are dropped here
  assign q_wr   = push && (stage_flush || (rd_entry[EW-1 -: LW] != '0));
  assign q_data = {stage_flush, rd_entry};

endmodule
`default_nettype wire

// ===== sv/hbp_back.sv =====
`default_nettype none
module hbp_back #(
  parameter int MAX_CODE_LEN = 30
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    q_valid,
  input  wire logic [MAX_CODE_LEN+$clog2(MAX_CODE_LEN+1):0] q_data,
  output logic                                         q_rd,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output logic      [hbp_pkg::BYTE_BITS-1:0]           out_byte,
  output logic                                         last_in_run,
  output logic                                         end_of_stream
);

  localparam int LW   = $clog2(MAX_CODE_LEN + 1);
  localparam int ACCW = MAX_CODE_LEN + hbp_pkg::BYTE_BITS;
  localparam int TW   = $clog2(ACCW + 1);
  localparam int BB   = hbp_pkg::BYTE_BITS;

  logic                    e_flush;
  logic [LW-1:0]           e_len;
  logic [MAX_CODE_LEN-1:0] e_code;

  // pending bits sit at the top of acc, everything below them is zero
  logic [ACCW-1:0] acc;
  logic [TW-1:0]   total;
  logic            busy;

  logic            slot_free;
  logic            emit;
  logic            pop_flush;
  logic            pop_code;
  logic [TW-1:0]   total_add;
  logic [TW-1:0]   shamt;
  logic [ACCW-1:0] acc_add;
  logic            final_byte;

  assign {e_flush, e_len, e_code} = q_data;

  assign slot_free  = !out_valid || out_ready;
  assign emit       = busy && slot_free;
  assign q_rd       = !busy && q_valid && (!e_flush || slot_free);
  assign pop_flush  = q_rd && e_flush;
  assign pop_code   = q_rd && !e_flush;
  assign final_byte = (total < TW'(2 * BB));

  assign total_add = total + TW'(e_len);
  assign shamt     = TW'(ACCW) - total_add;
  assign acc_add   = acc | ({{BB{1'b0}}, e_code} << shamt);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      total     <= '0;
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
      acc       <= acc << BB;
      total     <= total - TW'(BB);
      busy      <= !final_byte;
    end else if (pop_flush) begin
      out_valid <= 1'b1;
      acc       <= '0;
      total     <= '0;
    end else begin
      if (pop_code) begin
        acc   <= acc_add;
        total <= total_add;
        busy  <= (total_add >= TW'(BB));
      end
      if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit || pop_flush) begin
      out_byte      <= acc[ACCW-1 -: BB];
      last_in_run   <= pop_flush || final_byte;
      end_of_stream <= pop_flush;
    end
  end

endmodule
`default_nettype wire

// ===== sv/huffman_bit_packer.sv =====
`default_nettype none
// Channel  Dir  tdata (low bit up)                                   tuser           tlast
// s_*      in   symbol[7:0] code_bits[37:8] code_length[42:38], pad  kind[1:0]       -
// m_*      out  out_byte[7:0]                                        end_of_stream   last_in_run
//
// Front: a beat is taken when the one-entry lookup stage is free or drains into the
// queue; loads write the table, encodes read it, results reach the back through the queue.
// Back: an encode is dequeued, then its whole bytes are emitted in turn, with no new entry
// taken meanwhile (up to 4 bytes); a flush emits the partial byte. The back's bit window sets the rate.
// Reset clears the partial byte and the queue; the code table is not cleared.
// m_tready low holds the output register; the queue then fills and s_tready drops.
module huffman_bit_packer #(
  parameter int SYMBOL_COUNT = 256,
  parameter int MAX_CODE_LEN = 30
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // symbol[7:0], code_bits[37:8], code_length[42:38], zero pad
  input  wire logic [hbp_pkg::S_DATA_W-1:0]  s_tdata,
  // kind[1:0]
  input  wire logic [hbp_pkg::KIND_W-1:0]    s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // out_byte[7:0]
  output logic      [hbp_pkg::BYTE_BITS-1:0] m_tdata,
  output logic                               m_tlast,
  // end_of_stream
  output logic                               m_tuser
);

  localparam int LW      = $clog2(MAX_CODE_LEN + 1);
  localparam int QW      = MAX_CODE_LEN + LW + 1;
  localparam int Q_DEPTH = 2;

  localparam int SYM_LO  = 0;
  localparam int CODE_LO = SYM_LO + hbp_pkg::SYMBOL_W;
  localparam int LEN_LO  = CODE_LO + hbp_pkg::CODE_W;

  logic          f_wr;
  logic [QW-1:0] f_data;
  logic          f_ready;
  logic          b_rd;
  logic          b_valid;
  logic [QW-1:0] b_data;

  hbp_front #(
    .SYMBOL_COUNT(SYMBOL_COUNT),
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .kind       (s_tuser),
    .symbol     (s_tdata[SYM_LO +: hbp_pkg::SYMBOL_W]),
    .code_bits  (s_tdata[CODE_LO +: hbp_pkg::CODE_W]),
    .code_length(s_tdata[LEN_LO +: hbp_pkg::LEN_W]),
    .q_wr       (f_wr),
    .q_data     (f_data),
    .q_ready    (f_ready)
  );

  hbp_queue #(
    .WIDTH(QW),
    .DEPTH(Q_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (f_wr),
    .wr_data (f_data),
    .wr_ready(f_ready),
    .rd_en   (b_rd),
    .rd_valid(b_valid),
    .rd_data (b_data)
  );

  hbp_back #(
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (b_valid),
    .q_data       (b_data),
    .q_rd         (b_rd),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_byte     (m_tdata),
    .last_in_run  (m_tlast),
    .end_of_stream(m_tuser)
  );

endmodule
`default_nettype wire
